>>> hw/rtl/masked_rgba_box_downsample_2x2_macros.svh
// Assertion helpers for the RTL.
`ifndef MASKED_RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define MASKED_RGBA_BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrbd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrbd check failed");

`endif

>>> hw/rtl/mrbd_pkg.sv
`default_nettype none

package mrbd_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int POS_W      = $clog2(MAX_WIDTH);

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SOURCE_MASK = CFG_IDX_W'(2);

    // Horizontal pair sum kept per output column of the last even row
    typedef struct packed {
        logic [3:0][8:0] sum;
        logic            fill;
        logic [7:0]      src;
    } t_pair;

    localparam int PAIR_W = $bits(t_pair);

endpackage

`default_nettype wire

>>> hw/rtl/mrbd_in_if.sv
`default_nettype none

interface mrbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic [7:0] in_fill_mask;
    logic [7:0] in_source_mask;

    modport source (
        output valid, in_red, in_green, in_blue, in_alpha, in_fill_mask, in_source_mask,
        input  ready
    );
    modport sink (
        input  valid, in_red, in_green, in_blue, in_alpha, in_fill_mask, in_source_mask,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/mrbd_out_if.sv
`default_nettype none

interface mrbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_fill_flag;
    logic [7:0] out_source_value;
    logic       frame_end;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_fill_flag,
               out_source_value, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_fill_flag,
               out_source_value, frame_end,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/mrbd_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
module mrbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/masked_rgba_box_downsample_2x2.sv
// 2x2 box downsampler for a masked RGBA raster stream. Source pixels enter on i_px in
// raster order, one per cycle while o_px is not stalled; one half-size pixel leaves
// on o_px when the bottom-right pixel of each 2x2 block is taken, via the stage-1
// register (line-buffer read) and the output register. Each pixel makes a single
// line-buffer read, issued as the pixel is accepted, and at most one write
// from the following stage, on a 2048 x 45-bit memory holding the horizontal pair
// sums of the last even row. The memory needs no clearing pass after reset. A
// register write restarts the frame at the top-left pixel; a width or height of 0
// acts as 1, values above 4096 saturate, an odd last row or column is dropped.
`default_nettype none

`include "masked_rgba_box_downsample_2x2_macros.svh"

module masked_rgba_box_downsample_2x2 (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mrbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mrbd_pkg::CFG_W-1:0]     i_cfg_data,
    mrbd_in_if.sink                             i_px,
    mrbd_out_if.source                          o_px
);

    localparam int CW = mrbd_pkg::CFG_W;
    localparam int PW = mrbd_pkg::POS_W;
    localparam int AW = mrbd_pkg::LINE_AW;

    // Stage-1 word: accepted pixel plus its position flags
    typedef struct packed {
        logic [3:0][7:0] px;
        logic            fill;
        logic [7:0]      src;
        logic [AW-1:0]   ocol;
        logic            w1;
        logic            h1;
        logic            odd_col;
        logic            odd_row;
        logic            fend;
    } t_s1;

    // Even-column pixel waiting for its right neighbor
    typedef struct packed {
        logic [3:0][7:0] px;
        logic            fill;
        logic [7:0]      src;
    } t_hold;

    typedef struct packed {
        logic [3:0][7:0] px;
        logic            fill;
        logic [7:0]      src;
        logic            fend;
    } t_out;

    // Configuration registers
    logic [CW-1:0] r_width;
    logic [CW-1:0] r_height;
    logic          r_use_src;

    // Frame position
    logic [PW-1:0] r_col, n_col;
    logic [PW-1:0] r_row, n_row;

    // Pipeline
    logic  r_s1_valid;
    t_s1   r_s1;
    t_s1   n_s1;
    t_hold r_hold;
    logic  r_out_valid;
    t_out  r_out;
    t_out  n_out;

    // Line buffer forwarding
    logic             r_byp_hit;
    mrbd_pkg::t_pair  r_byp_data;

    logic          accept;
    logic          s1_adv;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] h_eff;
    logic [CW-1:0] dw_m1;
    logic [CW-1:0] dh_m1;
    logic [CW-1:0] col_inc;
    logic [CW-1:0] row_inc;

    mrbd_pkg::t_pair pair;
    mrbd_pkg::t_pair up;
    mrbd_pkg::t_pair ram_rdata;
    logic [3:0][9:0] tot;
    logic            have_pair;
    logic            s1_emit;
    logic            s1_wr;
    logic            s1_hold_ld;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic            fwd_hit;

    // Effective frame size and half-size limits
    always_comb begin
        w_eff = (r_width == '0) ? CW'(1) :
                (r_width > CW'(mrbd_pkg::MAX_WIDTH)) ? CW'(mrbd_pkg::MAX_WIDTH) : r_width;
        h_eff = (r_height == '0) ? CW'(1) :
                (r_height > CW'(mrbd_pkg::MAX_HEIGHT)) ? CW'(mrbd_pkg::MAX_HEIGHT) : r_height;
        dw_m1 = ((w_eff >> 1) == '0) ? '0 : (w_eff >> 1) - CW'(1);
        dh_m1 = ((h_eff >> 1) == '0) ? '0 : (h_eff >> 1) - CW'(1);
    end

    // Handshake
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_px.ready);
    assign i_px.ready = !r_s1_valid || s1_adv;
    assign accept     = i_px.valid && i_px.ready;

    // Position counters and stage-1 word
    always_comb begin
        col_inc = CW'(r_col) + CW'(1);
        row_inc = CW'(r_row) + CW'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (accept) begin
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = (row_inc >= h_eff) ? '0 : row_inc[PW-1:0];
            end else begin
                n_col = col_inc[PW-1:0];
            end
        end

        n_s1.px      = {i_px.in_alpha, i_px.in_blue, i_px.in_green, i_px.in_red};
        n_s1.fill    = |i_px.in_fill_mask;
        n_s1.src     = i_px.in_source_mask;
        n_s1.ocol    = r_col[PW-1:1];
        n_s1.w1      = (w_eff == CW'(1));
        n_s1.h1      = (h_eff == CW'(1));
        n_s1.odd_col = r_col[0];
        n_s1.odd_row = r_row[0];
        n_s1.fend    = (CW'(r_col[PW-1:1]) == dw_m1) && (CW'(r_row[PW-1:1]) == dh_m1);
    end

    // Stage 2: combine with held pixel and upper pair
    always_comb begin
        have_pair  = r_s1.w1 || r_s1.odd_col;
        s1_emit    = have_pair && (r_s1.h1 || r_s1.odd_row);
        s1_wr      = have_pair && !r_s1.h1 && !r_s1.odd_row;
        s1_hold_ld = !r_s1.w1 && !r_s1.odd_col;

        for (int c = 0; c < 4; c++) begin
            pair.sum[c] = r_s1.w1 ? {r_s1.px[c], 1'b0}
                                  : 9'(r_hold.px[c]) + 9'(r_s1.px[c]);
        end
        pair.fill = r_s1.w1 ? r_s1.fill : (r_hold.fill | r_s1.fill);
        pair.src  = (!r_s1.w1 && (r_hold.src != '0)) ? r_hold.src : r_s1.src;

        up = r_byp_hit ? r_byp_data : ram_rdata;

        for (int c = 0; c < 4; c++) begin
            tot[c] = r_s1.h1 ? {pair.sum[c], 1'b0}
                             : 10'(up.sum[c]) + 10'(pair.sum[c]);
            n_out.px[c] = tot[c][9:2];
        end
        n_out.fill = r_s1.h1 ? pair.fill : (up.fill | pair.fill);
        n_out.src  = !r_use_src ? 8'd0 :
                     (!r_s1.h1 && (up.src != '0)) ? up.src : pair.src;
        n_out.fend = r_s1.fend;
    end

    // Line buffer access: read at accept, write from stage 2
    assign ram_we    = s1_adv && s1_wr;
    assign ram_raddr = r_col[PW-1:1];
    assign fwd_hit   = ram_we && (ram_raddr == r_s1.ocol);

    mrbd_ram #(
        .WIDTH (mrbd_pkg::PAIR_W),
        .DEPTH (mrbd_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.ocol),
        .i_wdata (pair),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CW'(1);
            r_height    <= CW'(1);
            r_use_src   <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_hit   <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == mrbd_pkg::CFG_SOURCE_WIDTH ||
                             i_cfg_idx == mrbd_pkg::CFG_SOURCE_HEIGHT ||
                             i_cfg_idx == mrbd_pkg::CFG_USE_SOURCE_MASK)) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mrbd_pkg::CFG_SOURCE_WIDTH:    r_width   <= i_cfg_data;
                    mrbd_pkg::CFG_SOURCE_HEIGHT:   r_height  <= i_cfg_data;
                    mrbd_pkg::CFG_USE_SOURCE_MASK: r_use_src <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                r_byp_hit  <= fwd_hit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= s1_emit;
            end else if (o_px.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= n_s1;
            r_byp_data <= pair;
        end
        if (s1_adv && s1_hold_ld) begin
            r_hold.px   <= r_s1.px;
            r_hold.fill <= r_s1.fill;
            r_hold.src  <= r_s1.src;
        end
        if (s1_adv && s1_emit) begin
            r_out <= n_out;
        end
    end

    // Output word
    assign o_px.valid            = r_out_valid;
    assign o_px.out_red          = r_out.px[0];
    assign o_px.out_green        = r_out.px[1];
    assign o_px.out_blue         = r_out.px[2];
    assign o_px.out_alpha        = r_out.px[3];
    assign o_px.out_fill_flag    = r_out.fill;
    assign o_px.out_source_value = r_out.src;
    assign o_px.frame_end        = r_out.fend;

    // Checks
    `MRBD_ASSERT_NOW(a_pair_write_xor_emit, i_clk, i_rst_n, r_s1_valid, !(s1_wr && s1_emit))
    `MRBD_ASSERT_NEXT(a_cfg_restarts_frame, i_clk, i_rst_n,
        i_cfg_we && i_cfg_idx == mrbd_pkg::CFG_SOURCE_WIDTH, r_col == '0 && r_row == '0)
    `MRBD_ASSERT_NOW(a_col_in_frame, i_clk, i_rst_n, 1'b1, CW'(r_col) < w_eff)
    `MRBD_ASSERT_NEXT(a_out_only_from_emit, i_clk, i_rst_n,
        !r_out_valid && !(r_s1_valid && s1_emit), !r_out_valid)

endmodule

`default_nettype wire

>>> sim/downsample_checker.sv
// Watches the pixel channels and the register port, predicts every half-size
// word and compares each accepted output word with the oldest prediction.
module downsample_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mrbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mrbd_pkg::CFG_W-1:0]     i_cfg_data,
    mrbd_in_if                             i_px_in,
    mrbd_out_if                            i_px_out,
    output int                             o_err_cnt,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 30;
    localparam int CFG_W       = mrbd_pkg::CFG_W;
    localparam int CFG_IDX_W   = mrbd_pkg::CFG_IDX_W;
    localparam int MAX_WIDTH   = mrbd_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = mrbd_pkg::MAX_HEIGHT;
    localparam int LINE_DEPTH  = mrbd_pkg::LINE_DEPTH;

    // horizontal pair: channel sums, fill flag, first nonzero source byte
    typedef struct packed {
        logic [3:0][9:0] sum;
        logic            fill;
        logic [7:0]      src;
    } pair_acc_t;

    // one half-size word; chan[0..3] = red, green, blue, alpha
    typedef struct packed {
        logic [3:0][7:0] chan;
        logic            fill;
        logic [7:0]      src;
        logic            frame_end;
    } half_px_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             src_mask_en;
    int unsigned      col_pos;
    int unsigned      row_pos;
    pair_acc_t        left_hold;
    pair_acc_t        upper_line [LINE_DEPTH];
    half_px_t         half_px_q [$];
    int               err_cnt;

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] val, int unsigned limit);
        if (val == '0) return 1;
        if (val > limit) return limit;
        return 32'(val);
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // any register write restarts the frame at the top-left pixel
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            mrbd_pkg::CFG_SOURCE_WIDTH: begin
                width_reg = val;
                col_pos   = 0;
                row_pos   = 0;
            end
            mrbd_pkg::CFG_SOURCE_HEIGHT: begin
                height_reg = val;
                col_pos    = 0;
                row_pos    = 0;
            end
            mrbd_pkg::CFG_USE_SOURCE_MASK: begin
                src_mask_en = val[0];
                col_pos     = 0;
                row_pos     = 0;
            end
            default: ;
        endcase
    endtask

    task automatic predict_half_px(input logic [3:0][7:0] chan, input logic [7:0] fill_b,
                                   input logic [7:0] src_b);
        int unsigned     w;
        int unsigned     h;
        int unsigned     ocol;
        int unsigned     orow;
        int unsigned     dw;
        int unsigned     dh;
        pair_acc_t       pr;
        pair_acc_t       up;
        logic [3:0][9:0] tot;
        logic            have_pair;
        logic            emit;
        logic            ofill;
        logic [7:0]      osrc;
        half_px_t        res;

        w         = clamp_size(width_reg, MAX_WIDTH);
        h         = clamp_size(height_reg, MAX_HEIGHT);
        have_pair = 1'b0;
        emit      = 1'b0;
        ocol      = 0;
        orow      = 0;
        ofill     = 1'b0;
        osrc      = '0;
        tot       = '0;
        pr        = '0;

        // horizontal stage
        if (w == 1) begin
            // single column: the pixel stands for both halves of its pair
            for (int c = 0; c < 4; c++) pr.sum[c] = {1'b0, chan[c], 1'b0};
            pr.fill   = (fill_b != 0);
            pr.src    = src_b;
            have_pair = 1'b1;
        end else if (col_pos[0]) begin
            for (int c = 0; c < 4; c++) pr.sum[c] = left_hold.sum[c] + 10'(chan[c]);
            pr.fill   = left_hold.fill | (fill_b != 0);
            pr.src    = (left_hold.src != 0) ? left_hold.src : src_b;
            have_pair = 1'b1;
            ocol      = col_pos >> 1;
        end else begin
            for (int c = 0; c < 4; c++) left_hold.sum[c] = 10'(chan[c]);
            left_hold.fill = (fill_b != 0);
            left_hold.src  = src_b;
        end

        // vertical stage: even rows park the pair, odd rows combine; one row emits at once
        if (have_pair && ocol < LINE_DEPTH) begin
            if (h == 1) begin
                for (int c = 0; c < 4; c++) tot[c] = {pr.sum[c][8:0], 1'b0};
                ofill = pr.fill;
                osrc  = pr.src;
                emit  = 1'b1;
            end else if (!row_pos[0]) begin
                upper_line[ocol] = pr;
            end else begin
                up = upper_line[ocol];
                for (int c = 0; c < 4; c++) tot[c] = up.sum[c] + pr.sum[c];
                ofill = up.fill | pr.fill;
                osrc  = (up.src != 0) ? up.src : pr.src;
                orow  = row_pos >> 1;
                emit  = 1'b1;
            end
        end

        if (emit) begin
            dw = (w / 2 != 0) ? w / 2 : 1;
            dh = (h / 2 != 0) ? h / 2 : 1;
            for (int c = 0; c < 4; c++) res.chan[c] = tot[c][9:2];
            res.fill      = ofill;
            res.src       = src_mask_en ? osrc : 8'h00;
            res.frame_end = (ocol == dw - 1) && (orow == dh - 1);
            half_px_q     = {half_px_q, res};
        end

        // advance raster position, wrap at frame end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic check_half_px();
        half_px_t want;
        if (half_px_q.size() == 0) begin
            report_mismatch("output word with no prediction pending");
        end else begin
            want = half_px_q.pop_front();
            compare_field("red", i_px_out.out_red, want.chan[0]);
            compare_field("green", i_px_out.out_green, want.chan[1]);
            compare_field("blue", i_px_out.out_blue, want.chan[2]);
            compare_field("alpha", i_px_out.out_alpha, want.chan[3]);
            compare_field("fill_flag", 8'(i_px_out.out_fill_flag), 8'(want.fill));
            compare_field("source_value", i_px_out.out_source_value, want.src);
            compare_field("frame_end", 8'(i_px_out.frame_end), 8'(want.frame_end));
        end
    endtask

    // output side first: a word leaving now stems from an earlier input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg   = CFG_W'(1);
            height_reg  = CFG_W'(1);
            src_mask_en = 1'b0;
            col_pos     = 0;
            row_pos     = 0;
            left_hold   = '0;
            half_px_q.delete();
        end else begin
            if (i_px_out.valid && i_px_out.ready) check_half_px();
            if (i_cfg_we) apply_cfg(i_cfg_idx, i_cfg_data);
            if (i_px_in.valid && i_px_in.ready) begin
                predict_half_px({i_px_in.in_alpha, i_px_in.in_blue, i_px_in.in_green,
                                 i_px_in.in_red}, i_px_in.in_fill_mask, i_px_in.in_source_mask);
            end
        end
        o_err_cnt = err_cnt;
        o_pending = half_px_q.size();
    end

endmodule

>>> sim/tb_top.sv
// Stimulus and verdict for the 2x2 masked RGBA downsampler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WIDE_ITEMS     = 400;
    localparam int RANDOM_ITEMS   = 600;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam int CFG_W      = mrbd_pkg::CFG_W;
    localparam int CFG_IDX_W  = mrbd_pkg::CFG_IDX_W;
    localparam int MAX_WIDTH  = mrbd_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = mrbd_pkg::MAX_HEIGHT;

    // index outside the register map; writes to it are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   err_cnt;
    int                   pending;
    bit                   hold_req = 1'b0;
    bit                   steady   = 1'b0;

    mrbd_in_if  px_in_if ();
    mrbd_out_if px_out_if ();

    masked_rgba_box_downsample_2x2 u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_px       (px_in_if),
        .o_px       (px_out_if)
    );

    downsample_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_px_in    (px_in_if),
        .i_px_out   (px_out_if),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // size register value: zero, oversize, extremes, and mostly small
    function automatic logic [CFG_W-1:0] pick_size(input int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return CFG_W'($urandom_range(limit + 1, (1 << CFG_W) - 1));
        if (r < 14) return CFG_W'(limit);
        if (r < 24) return CFG_W'(1);
        if (r < 30) return CFG_W'(2);
        return CFG_W'($urandom_range(2, 9));
    endfunction

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] val, input int limit);
        if (val == '0) return 1;
        if (val > limit) return limit;
        return 32'(val);
    endfunction

    // offer one word and hold it until it is accepted
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha,
                              input logic [7:0] fill_m, input logic [7:0] src_m);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            px_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        px_in_if.valid          <= 1'b1;
        px_in_if.in_red         <= red;
        px_in_if.in_green       <= green;
        px_in_if.in_blue        <= blue;
        px_in_if.in_alpha       <= alpha;
        px_in_if.in_fill_mask   <= fill_m;
        px_in_if.in_source_mask <= src_m;
        do @(posedge clk); while (!px_in_if.ready);
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                   ($urandom_range(0, 9) < 7) ? 8'h00 : rand_byte(),
                   ($urandom_range(0, 1) == 0) ? 8'h00 : rand_byte());
    endtask

    // stop offering, let every predicted word drain, then let the pipe settle
    task automatic wait_idle();
        px_in_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                              input logic mask_en, input bit spare);
        cfg_we   <= 1'b1;
        cfg_idx  <= mrbd_pkg::CFG_SOURCE_WIDTH;
        cfg_data <= w_val;
        @(posedge clk);
        cfg_idx  <= mrbd_pkg::CFG_SOURCE_HEIGHT;
        cfg_data <= h_val;
        @(posedge clk);
        cfg_idx  <= mrbd_pkg::CFG_USE_SOURCE_MASK;
        cfg_data <= CFG_W'(mask_en);
        @(posedge clk);
        if (spare) begin
            cfg_idx  <= CFG_SPARE_IDX;
            cfg_data <= CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_config(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                              input logic mask_en, input bit spare, input int n_items);
        wait_idle();
        write_regs(w_val, h_val, mask_en, spare);
        repeat (n_items) send_random_pixel();
    endtask

    // output side: random ready runs and stalls, one long hold on request
    initial begin : sink_side
        int run_len;
        int stall_len;
        bit held;
        held = 1'b0;
        px_out_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            px_out_if.ready <= 1'b1;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
            @(posedge clk);
            for (int i = 1; i < run_len && !(hold_req && !held); i++) @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                px_out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                stall_len = pick_gap();
                if (stall_len > 0) begin
                    px_out_if.ready <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
            end
        end
    end

    // input side and verdict
    initial begin : source_side
        int               sent;
        int               n;
        int unsigned      area;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        int               k;

        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= '0;
        cfg_data                <= '0;
        px_in_if.valid          <= 1'b0;
        px_in_if.in_red         <= '0;
        px_in_if.in_green       <= '0;
        px_in_if.in_blue        <= '0;
        px_in_if.in_alpha       <= '0;
        px_in_if.in_fill_mask   <= '0;
        px_in_if.in_source_mask <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset config (1x1, source masking off): each pixel is a whole block
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        // 2x2: full-scale block with source only bottom-right, then small sums
        wait_idle();
        write_regs(CFG_W'(2), CFG_W'(2), 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd4, 8'h00, 8'h01);
        send_pixel(8'd2, 8'd3, 8'd4, 8'd5, 8'h00, 8'hFF);
        send_pixel(8'd3, 8'd4, 8'd5, 8'd6, 8'h01, 8'h00);
        send_pixel(8'd4, 8'd5, 8'd6, 8'd7, 8'h00, 8'h00);

        // 3x3: odd last row and column are dropped and must not leak in
        wait_idle();
        write_regs(CFG_W'(3), CFG_W'(3), 1'b1, 1'b1);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                k = r * 2 + c;
                if (r == 2 || c == 2)
                    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55);
                else
                    send_pixel(8'(40 * k), 8'(40 * k + 1), 8'(255 - 40 * k), 8'(k),
                               8'h00, (k == 3) ? 8'h7F : 8'h00);
            end
        end

        // zero size acts as one
        wait_idle();
        write_regs('0, '0, 1'b1, 1'b0);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'hAA);

        // back pressure: the sink holds off while full frames keep coming
        wait_idle();
        write_regs(CFG_W'(4), CFG_W'(4), 1'b1, 1'b0);
        steady = 1'b1;
        hold_req <= 1'b1;
        repeat (12 * 16) send_random_pixel();

        // start of a row at the widest size
        run_config(CFG_W'(MAX_WIDTH), CFG_W'(1), 1'($urandom_range(0, 1)), 1'b0, WIDE_ITEMS);
        steady = 1'b0;

        // random configs: mostly whole frames, large sizes only in part
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w_val = pick_size(MAX_WIDTH);
            h_val = pick_size(MAX_HEIGHT);
            area  = eff_size(w_val, MAX_WIDTH) * eff_size(h_val, MAX_HEIGHT);
            if (area <= 160) begin
                n = area * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, area);
            end else begin
                n = $urandom_range(20, 120);
            end
            steady = ($urandom_range(0, 4) == 0);
            run_config(w_val, h_val, 1'($urandom_range(0, 1)), ($urandom_range(0, 15) == 0), n);
            sent += n;
        end
        steady = 1'b0;

        wait_idle();
        if (err_cnt == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> masked_rgba_box_downsample_2x2.f
+incdir+hw/rtl
hw/rtl/mrbd_pkg.sv
hw/rtl/mrbd_in_if.sv
hw/rtl/mrbd_out_if.sv
hw/rtl/mrbd_ram.sv
hw/rtl/masked_rgba_box_downsample_2x2.sv
sim/downsample_checker.sv
sim/tb_top.sv
